// ===== rtl/ukt_pkg.sv =====
// ----------------------------------------------------------------------------
// Unsorted keyed table package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ukt_pkg;

   localparam int CAPACITY  = 16;
   localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int KEY_W     = 16;
   localparam int PAY_W     = 32;
   localparam int CMD_W     = 3;
   localparam int STAT_W    = 2;
   localparam int COUNT_W   = 5;
   localparam int REQ_DATA_W = KEY_W + PAY_W;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_LOOKUP = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_READ   = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2,
      ST_END  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_MOVE,
      S_RDWAIT,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_FIRST,
      RD_NEXT,
      RD_LAST,
      RD_POS
   } rd_sel_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic       take_req;
      rd_sel_type rd_sel;
      logic       wr_ins;
      logic       wr_move;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       clear;
      logic       rp_inc;
      logic       scan_rst;
      logic       scan_inc;
      logic       hit_save;
      logic       rd_save;
      logic       set_status;
      status_type status_val;
      logic       rsp_load;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    rp_lt_cnt;
      logic    key_hit;
      logic    scan_last;
      logic    found;
      logic    rsp_free;
   } sts_type;

endpackage

// ===== rtl/ukt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Unsorted keyed table controller
// Sequences one request at a time: dispatch, scan, move, read and respond.
// ----------------------------------------------------------------------------
module ukt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ukt_pkg::sts_type sts,
   output ukt_pkg::ctl_type ctl
);
   import ukt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (sts.cmd) inside
               CMD_DELETE, CMD_LOOKUP: state_in = sts.empty ? S_DONE : S_SCAN;
               CMD_READ:               state_in = sts.rp_lt_cnt ? S_RDWAIT : S_DONE;
               default:                state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            if (sts.cmd == CMD_DELETE && sts.key_hit) begin
               state_in = S_MOVE;
            end else if (sts.scan_last) begin
               state_in = S_DONE;
            end
         end
         S_MOVE:   state_in = S_DONE;
         S_RDWAIT: state_in = S_DONE;
         S_DONE: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl        = '0;
      ctl.rd_sel = RD_FIRST;
      ctl.status_val = ST_OK;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            ctl.take_req = req_tvalid;
         end
         S_EXEC: begin
            case (sts.cmd) inside
               CMD_INSERT: begin
                  if (sts.full) begin
                     ctl.set_status = 1'b1;
                     ctl.status_val = ST_FULL;
                  end else begin
                     ctl.wr_ins  = 1'b1;
                     ctl.cnt_inc = 1'b1;
                  end
               end
               CMD_DELETE, CMD_LOOKUP: begin
                  if (sts.empty) begin
                     ctl.set_status = 1'b1;
                     ctl.status_val = ST_MISS;
                  end else begin
                     ctl.rd_sel   = RD_FIRST;
                     ctl.scan_rst = 1'b1;
                  end
               end
               CMD_CLEAR: ctl.clear = 1'b1;
               CMD_READ: begin
                  if (sts.rp_lt_cnt) begin
                     ctl.rd_sel = RD_POS;
                  end else begin
                     ctl.set_status = 1'b1;
                     ctl.status_val = ST_END;
                  end
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            if (sts.cmd == CMD_DELETE) begin
               if (sts.key_hit) begin
                  ctl.hit_save = 1'b1;
                  ctl.rd_sel   = RD_LAST;
               end else if (sts.scan_last) begin
                  ctl.set_status = 1'b1;
                  ctl.status_val = ST_MISS;
               end else begin
                  ctl.rd_sel   = RD_NEXT;
                  ctl.scan_inc = 1'b1;
               end
            end else begin
               // lookup: last match wins
               ctl.hit_save = sts.key_hit;
               if (sts.scan_last) begin
                  ctl.set_status = !(sts.found || sts.key_hit);
                  ctl.status_val = ST_MISS;
               end else begin
                  ctl.rd_sel   = RD_NEXT;
                  ctl.scan_inc = 1'b1;
               end
            end
         end
         S_MOVE: begin
            ctl.wr_move = 1'b1;
            ctl.cnt_dec = 1'b1;
         end
         S_RDWAIT: begin
            ctl.rd_save = 1'b1;
            ctl.rp_inc  = 1'b1;
         end
         S_DONE: begin
            ctl.rsp_load = sts.rsp_free;
         end
         default: ;
      endcase
   end

   a_move_after_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |-> ($past(state_ff) == S_SCAN))
      else $error("move step entered without a preceding scan");

   a_take_to_exec : assert property (@(posedge clock) disable iff (reset)
      ctl.take_req |=> (state_ff == S_EXEC))
      else $error("accepted request not dispatched");

   a_load_to_idle : assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |=> (state_ff == S_IDLE))
      else $error("controller not idle after response load");

endmodule

// ===== rtl/ukt_dpath.sv =====
// ----------------------------------------------------------------------------
// Unsorted keyed table datapath
// Entry memory, count, read position, scan index, result and output register.
// ----------------------------------------------------------------------------
module ukt_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ukt_pkg::CMD_W-1:0]          req_tuser,
   input  logic [ukt_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ukt_pkg::STAT_W-1:0]         rsp_tuser,
   output logic [ukt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  ukt_pkg::ctl_type                   ctl,
   output ukt_pkg::sts_type                   sts
);
   import ukt_pkg::*;

   entry_type              mem [CAPACITY];
   entry_type              rd_data_ff;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   entry_type              mem_wdata;

   cmd_type                req_cmd_ff, req_cmd_in;
   logic [KEY_W-1:0]       req_key_ff, req_key_in;
   logic [PAY_W-1:0]       req_pay_ff, req_pay_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       rp_ff, rp_in;
   logic [ADDR_W-1:0]      scan_ff, scan_in;
   logic [ADDR_W-1:0]      pos_ff, pos_in;
   status_type             res_status_ff, res_status_in;
   logic                   res_found_ff, res_found_in;
   logic [KEY_W-1:0]       res_key_ff, res_key_in;
   logic [PAY_W-1:0]       res_pay_ff, res_pay_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]      rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   is_full;
   logic                   tbl_empty;

   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign tbl_empty = (count_ff == '0);

   // entry memory
   always_comb begin
      unique case (ctl.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_NEXT:  rd_addr = scan_ff + ADDR_W'(1);
         RD_LAST:  rd_addr = ADDR_W'(count_ff - CNT_W'(1));
         RD_POS:   rd_addr = rp_ff[ADDR_W-1:0];
         default:  rd_addr = '0;
      endcase
      mem_we    = ctl.wr_ins || ctl.wr_move;
      mem_waddr = ctl.wr_move ? pos_ff : count_ff[ADDR_W-1:0];
      mem_wdata = ctl.wr_move ? rd_data_ff : entry_type'{key: req_key_ff, payload: req_pay_ff};
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[rd_addr];
   end

   // next values
   always_comb begin
      req_cmd_in    = req_cmd_ff;
      req_key_in    = req_key_ff;
      req_pay_in    = req_pay_ff;
      count_in      = count_ff;
      rp_in         = rp_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;

      if (ctl.take_req) begin
         req_cmd_in    = cmd_type'(req_tuser);
         req_key_in    = req_tdata[KEY_W-1:0];
         req_pay_in    = req_tdata[KEY_W+PAY_W-1:KEY_W];
         res_status_in = ST_OK;
         res_found_in  = 1'b0;
         res_key_in    = '0;
         res_pay_in    = '0;
      end

      if (ctl.clear) begin
         count_in = '0;
         rp_in    = '0;
      end else begin
         if (ctl.cnt_inc) count_in = count_ff + CNT_W'(1);
         if (ctl.cnt_dec) count_in = count_ff - CNT_W'(1);
         if (ctl.rp_inc)  rp_in    = rp_ff + CNT_W'(1);
      end

      if (ctl.scan_rst) scan_in = '0;
      if (ctl.scan_inc) scan_in = scan_ff + ADDR_W'(1);

      if (ctl.hit_save) begin
         pos_in       = scan_ff;
         res_found_in = 1'b1;
         res_key_in   = rd_data_ff.key;
         res_pay_in   = rd_data_ff.payload;
      end
      if (ctl.rd_save) begin
         res_key_in = rd_data_ff.key;
         res_pay_in = rd_data_ff.payload;
      end
      if (ctl.set_status) res_status_in = ctl.status_val;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = res_status_ff;
         rsp_data_in  = {tbl_empty, is_full, COUNT_W'(count_ff),
                         res_pay_ff, res_key_ff, res_found_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_cmd_ff    <= req_cmd_in;
      req_key_ff    <= req_key_in;
      req_pay_ff    <= req_pay_in;
      scan_ff       <= scan_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sts.cmd       = req_cmd_ff;
   assign sts.full      = is_full;
   assign sts.empty     = tbl_empty;
   assign sts.rp_lt_cnt = (rp_ff < count_ff);
   assign sts.key_hit   = (rd_data_ff.key == req_key_ff);
   assign sts.scan_last = ((CNT_W'(scan_ff) + CNT_W'(1)) == count_ff);
   assign sts.found     = res_found_ff;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_tready;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_move_nonempty : assert property (@(posedge clock) disable iff (reset)
      ctl.wr_move |-> (count_ff != '0))
      else $error("entry move on an empty table");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");

endmodule

// ===== rtl/unsorted_keyed_table.sv =====
// ----------------------------------------------------------------------------
// Unsorted keyed table
// Request accept to response: insert, clear, unused codes and delete/lookup on
// an empty table go from dispatch straight to the response register; read waits
// for the memory read; lookup scans one entry per cycle through the memory read
// port; delete scans and, on a hit, moves the last entry into the freed slot.
// One request in flight; the next is taken in the cycle after the response register loads.
// Reset clears count, read position, controller and response valid, not entries.
// ----------------------------------------------------------------------------
module unsorted_keyed_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ukt_pkg::CMD_W-1:0]       req_tuser,  // cmd
   input  logic [ukt_pkg::REQ_DATA_W-1:0]  req_tdata,  // key, payload_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ukt_pkg::STAT_W-1:0]      rsp_tuser,  // status
   // found, key_out, payload_out, count, is_full, empty flag
   output logic [ukt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ukt_pkg::*;

   ctl_type ctl;
   sts_type sts;

   ukt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   ukt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .ctl        (ctl),
      .sts        (sts)
   );

endmodule
